### src/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants of the reference picture table.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int unsigned REF_SLOTS = 8;
  localparam int unsigned SLOT_W    = $clog2(REF_SLOTS);
  localparam int unsigned LIVE_W    = $clog2(REF_SLOTS + 1);
  localparam int unsigned PIC_W     = 32;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CMP_W     = (LIVE_W > CFG_W) ? LIVE_W : CFG_W;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [CFG_W-1:0] FULL_LIVE_RESET = CFG_W'(3);

  typedef enum logic [REQ_W-1:0] {
    REQ_PICK_REFS     = 3'd0,
    REQ_PICK_RETIRE   = 3'd1,
    REQ_EXPIRE_ONE    = 3'd2,
    REQ_EXPIRE_BEFORE = 3'd3,
    REQ_INSERT        = 3'd4
  } rpt_req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_BACK = 2'd1,
    ST_FULL    = 2'd2
  } rpt_status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } rpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } rpt_sts_t;

  typedef struct packed {
    logic [PIC_W-1:0] back_ref;
    logic             back_found;
    logic [PIC_W-1:0] fwd_ref;
    logic             fwd_found;
    logic [PIC_W-1:0] retire_pick;
    logic             retire_found;
    rpt_status_e      status;
  } rpt_result_t;

endpackage

### src/rpt_if.sv
// ----------------------------------------------------------------------------
// rpt_if
// Request, result and configuration channels of the reference picture table.
// ----------------------------------------------------------------------------
interface rpt_req_if;
  logic                         valid;
  logic                         ready;
  logic [rpt_pkg::REQ_W-1:0]    req_type;
  logic [rpt_pkg::PIC_W-1:0]    picture_number;
  logic [rpt_pkg::PIC_W-1:0]    retire_number;
  logic                         retire_given;

  modport source (output valid, req_type, picture_number, retire_number, retire_given,
                  input ready);
  modport sink (input valid, req_type, picture_number, retire_number, retire_given,
                output ready);
endinterface

interface rpt_res_if;
  logic                         valid;
  logic                         ready;
  logic [rpt_pkg::PIC_W-1:0]    back_ref;
  logic                         back_found;
  logic [rpt_pkg::PIC_W-1:0]    fwd_ref;
  logic                         fwd_found;
  logic [rpt_pkg::PIC_W-1:0]    retire_pick;
  logic                         retire_found;
  logic [rpt_pkg::STATUS_W-1:0] status;

  modport source (output valid, back_ref, back_found, fwd_ref, fwd_found, retire_pick,
                  retire_found, status, input ready);
  modport sink (input valid, back_ref, back_found, fwd_ref, fwd_found, retire_pick,
                retire_found, status, output ready);
endinterface

interface rpt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rpt_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/rpt_ctrl.sv
// ----------------------------------------------------------------------------
// rpt_ctrl
// Sequencer: takes a request, steps the slot scan, finishes, hands over result.
// ----------------------------------------------------------------------------
module rpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output rpt_pkg::rpt_cmd_t cmd_o,
  input  rpt_pkg::rpt_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_OUT    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.finish = 1'b0;
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/rpt_datapath.sv
// ----------------------------------------------------------------------------
// rpt_datapath
// Slot table, one-slot-per-cycle scan unit and result register.
// ----------------------------------------------------------------------------
module rpt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpt_pkg::rpt_cmd_t             cmd_i,
  output rpt_pkg::rpt_sts_t             sts_o,
  input  logic [rpt_pkg::REQ_W-1:0]     req_type_i,
  input  logic [rpt_pkg::PIC_W-1:0]     picture_number_i,
  input  logic [rpt_pkg::PIC_W-1:0]     retire_number_i,
  input  logic                          retire_given_i,
  input  logic                          cfg_valid_i,
  input  logic [rpt_pkg::CFG_W-1:0]     cfg_data_i,
  output rpt_pkg::rpt_result_t          result_o
);

  // slot table
  logic [rpt_pkg::REF_SLOTS-1:0] used_q;
  logic [rpt_pkg::REF_SLOTS-1:0] exp_q;
  logic [rpt_pkg::PIC_W-1:0]     pic_mem_q [rpt_pkg::REF_SLOTS];

  logic [rpt_pkg::CFG_W-1:0] full_live_q;

  // captured request
  rpt_pkg::rpt_req_e          req_q;
  logic [rpt_pkg::PIC_W-1:0]  cur_q;
  logic [rpt_pkg::PIC_W-1:0]  ret_q;
  logic                       given_q;
  logic [rpt_pkg::SLOT_W-1:0] idx_q;

  // scan accumulators
  logic [rpt_pkg::PIC_W-1:0]  back_q, fwd_q, emin_q, amin_q;
  logic                       back_f_q, fwd_f_q, emin_f_q, amin_f_q;
  logic [rpt_pkg::LIVE_W-1:0] live_q;
  logic                       hit_q;
  logic [rpt_pkg::SLOT_W-1:0] hit_idx_q;

  rpt_pkg::rpt_result_t result_q;
  rpt_pkg::rpt_result_t result_d;

  logic [rpt_pkg::PIC_W-1:0] slot_pic;
  logic                      slot_used;
  logic                      slot_exp;
  logic                      lt_cur;
  logic                      gt_cur;
  logic                      do_insert;

  assign slot_pic  = pic_mem_q[idx_q];
  assign slot_used = used_q[idx_q];
  assign slot_exp  = exp_q[idx_q];
  assign lt_cur    = slot_pic < cur_q;
  assign gt_cur    = slot_pic > cur_q;
  assign do_insert = cmd_i.finish && (req_q == rpt_pkg::REQ_INSERT) && hit_q;

  assign sts_o.scan_last = (idx_q == rpt_pkg::SLOT_W'(rpt_pkg::REF_SLOTS - 1));
  assign result_o        = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_live_q <= rpt_pkg::FULL_LIVE_RESET;
    end else if (cfg_valid_i) begin
      full_live_q <= cfg_data_i;
    end
  end

  // used and expired marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      exp_q  <= '0;
    end else begin
      if (cmd_i.step && slot_used) begin
        if ((req_q == rpt_pkg::REQ_EXPIRE_ONE && slot_pic == cur_q) ||
            (req_q == rpt_pkg::REQ_EXPIRE_BEFORE && lt_cur)) begin
          exp_q[idx_q] <= 1'b1;
        end
      end
      if (do_insert) begin
        used_q[hit_idx_q] <= 1'b1;
        exp_q[hit_idx_q]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      pic_mem_q[hit_idx_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= rpt_pkg::rpt_req_e'(req_type_i);
      cur_q    <= picture_number_i;
      ret_q    <= retire_number_i;
      given_q  <= retire_given_i;
      idx_q    <= '0;
      back_q   <= '0;
      back_f_q <= 1'b0;
      fwd_q    <= '0;
      fwd_f_q  <= 1'b0;
      emin_q   <= '0;
      emin_f_q <= 1'b0;
      amin_q   <= '0;
      amin_f_q <= 1'b0;
      live_q   <= '0;
      hit_q    <= 1'b0;
      hit_idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + rpt_pkg::SLOT_W'(1);
      case (req_q)
        rpt_pkg::REQ_PICK_REFS: begin
          if (slot_used && lt_cur && (!back_f_q || slot_pic > back_q)) begin
            back_q   <= slot_pic;
            back_f_q <= 1'b1;
          end
          if (slot_used && !slot_exp && gt_cur && (!fwd_f_q || slot_pic < fwd_q)) begin
            fwd_q   <= slot_pic;
            fwd_f_q <= 1'b1;
          end
        end
        rpt_pkg::REQ_PICK_RETIRE: begin
          if (slot_used) begin
            live_q <= live_q + rpt_pkg::LIVE_W'(1);
            if (slot_exp && (!emin_f_q || slot_pic < emin_q)) begin
              emin_q   <= slot_pic;
              emin_f_q <= 1'b1;
            end
            // oldest overall, for the forced retirement
            if (!amin_f_q || slot_pic < amin_q) begin
              amin_q   <= slot_pic;
              amin_f_q <= 1'b1;
            end
          end
        end
        rpt_pkg::REQ_INSERT: begin
          // first empty slot or first slot holding the retired number
          if (!hit_q && (!slot_used || (given_q && slot_pic == ret_q))) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_d = '0;
    case (req_q)
      rpt_pkg::REQ_PICK_REFS: begin
        result_d.back_ref   = back_q;
        result_d.back_found = back_f_q;
        result_d.fwd_ref    = fwd_q;
        result_d.fwd_found  = fwd_f_q;
        result_d.status     = back_f_q ? rpt_pkg::ST_OK : rpt_pkg::ST_NO_BACK;
      end
      rpt_pkg::REQ_PICK_RETIRE: begin
        if (emin_f_q) begin
          result_d.retire_pick  = emin_q;
          result_d.retire_found = 1'b1;
        end else if (amin_f_q &&
                     rpt_pkg::CMP_W'(live_q) == rpt_pkg::CMP_W'(full_live_q)) begin
          result_d.retire_pick  = amin_q;
          result_d.retire_found = 1'b1;
        end
      end
      rpt_pkg::REQ_INSERT: begin
        if (!hit_q) begin
          result_d.status = rpt_pkg::ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

endmodule

### src/reference_picture_table.sv
// ----------------------------------------------------------------------------
// reference_picture_table
// Small table of reference pictures with selection, retirement and insertion.
// ----------------------------------------------------------------------------
// Each request is taken when the block is idle and answered with exactly one
// result. The table is walked one slot per cycle through a single shared set
// of comparators, after which a finish step registers the result; the next
// request is accepted only once that result has gone, so a new request is
// never taken while the last one is in flight. The full_live_count register
// is always ready and takes effect at once, so write it only while no request
// is in flight.
module reference_picture_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpt_cfg_if.sink    cfg_i,
  rpt_req_if.sink    req_i,
  rpt_res_if.source  res_o
);

  rpt_pkg::rpt_cmd_t    cmd;
  rpt_pkg::rpt_sts_t    sts;
  rpt_pkg::rpt_result_t result;
  logic                 req_ready;
  logic                 res_valid;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;
  assign res_o.valid = res_valid;

  assign res_o.back_ref     = result.back_ref;
  assign res_o.back_found   = result.back_found;
  assign res_o.fwd_ref      = result.fwd_ref;
  assign res_o.fwd_found    = result.fwd_found;
  assign res_o.retire_pick  = result.retire_pick;
  assign res_o.retire_found = result.retire_found;
  assign res_o.status       = result.status;

  rpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rpt_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .picture_number_i (req_i.picture_number),
    .retire_number_i  (req_i.retire_number),
    .retire_given_i   (req_i.retire_given),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .result_o         (result)
  );

endmodule

### bench/rpt_table_checker.sv
// ----------------------------------------------------------------------------
// rpt_table_checker
// Watches the configuration, request and result channels of the reference
// picture table, keeps its own copy of the slot table, predicts the answer to
// every accepted request and compares each result against the oldest one due.
// ----------------------------------------------------------------------------
module rpt_table_checker
  import rpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rpt_cfg_if          cfg_i,
  rpt_req_if          req_i,
  rpt_res_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_MAX = 10;

  logic [REF_SLOTS-1:0] slot_live;
  logic [REF_SLOTS-1:0] slot_gone;
  logic [PIC_W-1:0]     slot_pic [REF_SLOTS];
  logic [CFG_W-1:0]     live_limit;
  rpt_result_t          answer_q [$];

  // applies one request to the local table and returns the answer it gives
  function automatic rpt_result_t table_answer(input logic [REQ_W-1:0] kind,
                                               input logic [PIC_W-1:0] pic,
                                               input logic [PIC_W-1:0] ret,
                                               input logic given);
    rpt_result_t r;
    int          hit;
    int unsigned live;
    int          i;
    r    = '0;
    hit  = -1;
    live = 0;
    case (kind)
      REQ_PICK_REFS: begin
        for (i = 0; i < REF_SLOTS; i++) begin
          if (slot_live[i] && slot_pic[i] < pic &&
              (!r.back_found || slot_pic[i] > r.back_ref)) begin
            r.back_ref   = slot_pic[i];
            r.back_found = 1'b1;
          end
          // expired pictures never serve as forward references
          if (slot_live[i] && !slot_gone[i] && slot_pic[i] > pic &&
              (!r.fwd_found || slot_pic[i] < r.fwd_ref)) begin
            r.fwd_ref   = slot_pic[i];
            r.fwd_found = 1'b1;
          end
        end
        if (r.back_found) r.status = ST_OK;
        else r.status = ST_NO_BACK;
      end
      REQ_PICK_RETIRE: begin
        for (i = 0; i < REF_SLOTS; i++) begin
          if (slot_live[i]) begin
            live++;
            if (slot_gone[i] && (!r.retire_found || slot_pic[i] < r.retire_pick)) begin
              r.retire_pick  = slot_pic[i];
              r.retire_found = 1'b1;
            end
          end
        end
        // nothing expired: a table at its limit gives up its oldest picture
        if (!r.retire_found && live == live_limit) begin
          for (i = 0; i < REF_SLOTS; i++) begin
            if (slot_live[i] && (!r.retire_found || slot_pic[i] < r.retire_pick)) begin
              r.retire_pick  = slot_pic[i];
              r.retire_found = 1'b1;
            end
          end
        end
      end
      REQ_EXPIRE_ONE: begin
        for (i = 0; i < REF_SLOTS; i++)
          if (slot_live[i] && slot_pic[i] == pic) slot_gone[i] = 1'b1;
      end
      REQ_EXPIRE_BEFORE: begin
        for (i = 0; i < REF_SLOTS; i++)
          if (slot_live[i] && slot_pic[i] < pic) slot_gone[i] = 1'b1;
      end
      REQ_INSERT: begin
        for (i = 0; i < REF_SLOTS; i++)
          if (hit < 0 && (!slot_live[i] || (given && slot_pic[i] == ret))) hit = i;
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_live[hit] = 1'b1;
          slot_pic[hit]  = pic;
          slot_gone[hit] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input rpt_result_t want,
                               input rpt_result_t got);
    fail_count_o++;
    if (fail_count_o <= REPORT_MAX) begin
      $display("[%0t] mismatch, %s", $time, what);
      $display("  expected back %h/%b fwd %h/%b retire %h/%b status %0d",
               want.back_ref, want.back_found, want.fwd_ref, want.fwd_found,
               want.retire_pick, want.retire_found, want.status);
      $display("  actual   back %h/%b fwd %h/%b retire %h/%b status %0d",
               got.back_ref, got.back_found, got.fwd_ref, got.fwd_found,
               got.retire_pick, got.retire_found, got.status);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rpt_result_t want;
    rpt_result_t got;
    int          i;
    if (!rst_ni) begin
      slot_live = '0;
      slot_gone = '0;
      for (i = 0; i < REF_SLOTS; i++) slot_pic[i] = '0;
      live_limit   = FULL_LIVE_RESET;
      fail_count_o = 0;
      answer_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) live_limit = cfg_i.data;
      // a result leaving on the same edge belongs to the earlier request
      if (res_i.valid && res_i.ready) begin
        got.back_ref     = res_i.back_ref;
        got.back_found   = res_i.back_found;
        got.fwd_ref      = res_i.fwd_ref;
        got.fwd_found    = res_i.fwd_found;
        got.retire_pick  = res_i.retire_pick;
        got.retire_found = res_i.retire_found;
        got.status       = rpt_status_e'(res_i.status);
        if (answer_q.size() == 0) begin
          flag_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = answer_q.pop_front();
          if (got.back_ref !== want.back_ref || got.back_found !== want.back_found ||
              got.fwd_ref !== want.fwd_ref || got.fwd_found !== want.fwd_found ||
              got.retire_pick !== want.retire_pick ||
              got.retire_found !== want.retire_found || got.status !== want.status)
            flag_mismatch("result fields differ", want, got);
        end
      end
      if (req_i.valid && req_i.ready)
        answer_q.push_back(table_answer(req_i.req_type, req_i.picture_number,
                                        req_i.retire_number, req_i.retire_given));
    end
    pending_o = answer_q.size();
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the reference picture table: a directed walk through empty,
// forced-retire, expiry, replacement and full-table cases, then random
// decoder-like request streams over several limit settings and idle patterns,
// with one long result stall. Checking is left to rpt_table_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpt_pkg::*;

  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 188;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RECENT_MAX  = 10;

  localparam logic [REQ_W-1:0] REQ_RESERVED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RESERVED_HI = 3'd7;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  wire  [31:0] fail_count;
  wire  [31:0] pending;

  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 52;
  int unsigned sent          = 0;
  int unsigned cycles        = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  logic [PIC_W-1:0] next_pic;
  logic [PIC_W-1:0] recent_q [$];

  rpt_cfg_if cfg_ch ();
  rpt_req_if req_ch ();
  rpt_res_if res_ch ();

  reference_picture_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  rpt_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_ch),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the table backs up
  always @(negedge clk_i) begin
    if (!hold_done && sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [PIC_W-1:0] pic,
                          input logic [PIC_W-1:0] ret, input logic given);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= kind;
    req_ch.picture_number <= pic;
    req_ch.retire_number  <= ret;
    req_ch.retire_given   <= given;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
    if (kind == REQ_INSERT) begin
      recent_q.push_back(pic);
      if (recent_q.size() > RECENT_MAX) void'(recent_q.pop_front());
    end
  endtask

  // only changes the limit once the table has answered everything
  task automatic write_live_limit(input logic [CFG_W-1:0] limit);
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= limit;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly a decoder-like stream around next_pic, with some noise
  task automatic send_random_request();
    int unsigned      roll;
    int unsigned      pick;
    int unsigned      span;
    logic [REQ_W-1:0] kind;
    logic [PIC_W-1:0] pic;
    logic [PIC_W-1:0] ret;
    logic             given;
    roll  = $urandom_range(0, 99);
    pick  = $urandom_range(0, 99);
    given = 1'($urandom_range(0, 1));
    pic   = $urandom;
    ret   = $urandom;
    if (roll < 3) begin
      kind = REQ_W'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
    end else if (roll < 8) begin
      kind = REQ_W'($urandom_range(REQ_PICK_REFS, REQ_INSERT));
    end else if (pick < 30) begin
      kind     = REQ_INSERT;
      next_pic = next_pic + $urandom_range(1, 3);
      pic      = ($urandom_range(0, 9) == 0) ? next_pic - $urandom_range(0, 5) : next_pic;
      given    = ($urandom_range(0, 3) != 0);
      // lean towards the oldest recent pictures, as a retirement would
      if (recent_q.size() > 0 && $urandom_range(0, 7) != 0) begin
        span = (recent_q.size() > 4) ? 3 : recent_q.size() - 1;
        ret  = recent_q[$urandom_range(0, span)];
      end
    end else if (pick < 60) begin
      kind = REQ_PICK_REFS;
      pic  = next_pic + 2 - $urandom_range(0, 12);
    end else if (pick < 75) begin
      kind = REQ_PICK_RETIRE;
    end else if (pick < 87) begin
      kind = REQ_EXPIRE_ONE;
      pic  = (recent_q.size() > 0) ? recent_q[$urandom_range(0, recent_q.size() - 1)]
                                   : next_pic;
    end else begin
      kind = REQ_EXPIRE_BEFORE;
      pic  = next_pic - $urandom_range(2, 10);
    end
    send_req(kind, pic, ret, given);
  endtask

  initial begin
    int unsigned      ph;
    int unsigned      n;
    logic [CFG_W-1:0] limit;
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_PICK_REFS;
    req_ch.picture_number = '0;
    req_ch.retire_number  = '0;
    req_ch.retire_given   = 1'b0;
    res_ch.ready          = 1'b0;
    next_pic              = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed walk, starting from an empty table
    write_live_limit(4'd1);
    send_req(REQ_PICK_REFS, '0, '0, 1'b0);
    send_req(REQ_PICK_RETIRE, '0, '0, 1'b0);
    send_req(REQ_INSERT, 32'd100, '0, 1'b0);
    send_req(REQ_PICK_RETIRE, '0, '0, 1'b0);
    write_live_limit(FULL_LIVE_RESET);
    send_req(REQ_INSERT, 32'd200, '0, 1'b0);
    send_req(REQ_INSERT, 32'd300, '0, 1'b0);
    send_req(REQ_PICK_RETIRE, '0, '0, 1'b0);
    send_req(REQ_PICK_REFS, 32'd200, '0, 1'b0);
    send_req(REQ_PICK_REFS, '0, '0, 1'b0);
    send_req(REQ_PICK_REFS, '1, '0, 1'b0);
    send_req(REQ_EXPIRE_ONE, 32'd300, '0, 1'b0);
    send_req(REQ_PICK_REFS, 32'd200, '0, 1'b0);
    send_req(REQ_PICK_RETIRE, '0, '0, 1'b0);
    send_req(REQ_INSERT, 32'd400, 32'd300, 1'b1);
    send_req(REQ_EXPIRE_BEFORE, 32'd250, '0, 1'b0);
    send_req(REQ_PICK_RETIRE, '0, '0, 1'b0);
    send_req(REQ_INSERT, '0, '1, 1'b1);
    send_req(REQ_INSERT, '1, '0, 1'b0);
    send_req(REQ_INSERT, 32'd400, '0, 1'b0);
    send_req(REQ_EXPIRE_ONE, 32'd400, '0, 1'b0);
    send_req(REQ_INSERT, 32'd7, '0, 1'b0);
    send_req(REQ_INSERT, 32'd8, '0, 1'b0);
    send_req(REQ_INSERT, 32'd9, 32'd12345, 1'b1);
    send_req(REQ_INSERT, 32'd9, 32'd200, 1'b1);
    send_req(REQ_RESERVED_LO, '1, '1, 1'b1);
    send_req(REQ_RESERVED_HI, '0, '0, 1'b0);
    send_req(REQ_RESERVED_LO + 3'd1, '1, '0, 1'b1);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       limit = 4'd8;
        1:       limit = CFG_W'($urandom_range(2, 7));
        2:       limit = 4'd15;
        3:       limit = 4'd0;
        4:       limit = 4'd8;
        default: limit = 4'd1;
      endcase
      write_live_limit(limit);
      if (ph < 2) begin
        send_idle_pct = 25;
        recv_idle_pct = 52;
      end else if (ph < 4) begin
        send_idle_pct = 52;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // some phases start near the ends of the number range
      case (ph)
        1:       next_pic = 32'hFFFF_FFF0;
        3:       next_pic = 32'h0000_0004;
        default: next_pic = $urandom;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_random_request();
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (2 * REF_SLOTS) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
